@@ rtl/hca_pkg.sv @@
package hca_pkg;

	// defaults for the top level parameters
	localparam int DEF_MAX_WIDTH   = 64;
	localparam int DEF_MAX_HEIGHT  = 64;
	localparam int DEF_MAX_RADII   = 16;
	localparam int DEF_ANGLE_STEPS = 18;

	// angle table: 18 steps of 20 degrees
	localparam int TABLE_LEN = 18;
	localparam int KW        = 5;

	// field and register widths
	localparam int CMD_W   = 1;
	localparam int POS_W   = 6;
	localparam int PIX_W   = 8;
	localparam int DIM_W   = 7;
	localparam int RCNT_W  = 5;
	localparam int VAL_W   = 8;
	localparam int RAD_W   = 4;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// fixed point: Q1.14 trig, product, rounded offset, centre coordinate
	localparam int TRIG_W  = 16;
	localparam int PROD_W  = 22;
	localparam int RND_W   = 23;
	localparam int FRAC_W  = 14;
	localparam int OFF_W   = RND_W - FRAC_W;
	localparam int COORD_W = 10;
	localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1 << (FRAC_W - 1));

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOTE_WEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 3'd4;

	// reset values of the registers
	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH    = 7'd64;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT   = 7'd64;
	localparam logic [RCNT_W-1:0] RST_RADIUS_COUNT   = 5'd16;
	localparam logic [VAL_W-1:0]  RST_VOTE_WEIGHT    = 8'd10;
	localparam logic [VAL_W-1:0]  RST_PEAK_THRESHOLD = 8'd180;

	// input command codes
	localparam logic [CMD_W-1:0] CMD_VOTE   = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REPORT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COS,
		ST_SIN,
		ST_UPD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} hca_state_t;

	function automatic logic signed [TRIG_W-1:0] cos_q14(input logic [KW-1:0] k);
		logic signed [TRIG_W-1:0] t;
		case (k)
			5'd0:  t = 16'sd16384;
			5'd1:  t = 16'sd15396;
			5'd2:  t = 16'sd12551;
			5'd3:  t = 16'sd8192;
			5'd4:  t = 16'sd2845;
			5'd5:  t = -16'sd2845;
			5'd6:  t = -16'sd8192;
			5'd7:  t = -16'sd12551;
			5'd8:  t = -16'sd15396;
			5'd9:  t = -16'sd16384;
			5'd10: t = -16'sd15396;
			5'd11: t = -16'sd12551;
			5'd12: t = -16'sd8192;
			5'd13: t = -16'sd2845;
			5'd14: t = 16'sd2845;
			5'd15: t = 16'sd8192;
			5'd16: t = 16'sd12551;
			5'd17: t = 16'sd15396;
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [KW-1:0] k);
		logic signed [TRIG_W-1:0] t;
		case (k)
			5'd0:  t = 16'sd0;
			5'd1:  t = 16'sd5604;
			5'd2:  t = 16'sd10531;
			5'd3:  t = 16'sd14189;
			5'd4:  t = 16'sd16135;
			5'd5:  t = 16'sd16135;
			5'd6:  t = 16'sd14189;
			5'd7:  t = 16'sd10531;
			5'd8:  t = 16'sd5604;
			5'd9:  t = 16'sd0;
			5'd10: t = -16'sd5604;
			5'd11: t = -16'sd10531;
			5'd12: t = -16'sd14189;
			5'd13: t = -16'sd16135;
			5'd14: t = -16'sd16135;
			5'd15: t = -16'sd14189;
			5'd16: t = -16'sd10531;
			5'd17: t = -16'sd5604;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/hough_circle_accumulator_unit.sv @@
// vote item: accepted in idle, then per (radius, angle) pair the steps multiply cos,
//   multiply sin + read, and add + write only when the centre falls inside the image
// report item: per radius layer a scan of width*height cells, a drain step and the output handshake,
//   then a clear sweep over all 2^(address bits) entries (65536 at default sizes)
// one item in flight; the single multiplier and the one-read, one-write vote memory set the pace
// reset: async active low, then a clear sweep of the whole vote memory before the first request is taken
module hough_circle_accumulator_unit #(
	parameter int MAX_WIDTH   = hca_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = hca_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADII   = hca_pkg::DEF_MAX_RADII,
	parameter int ANGLE_STEPS = hca_pkg::DEF_ANGLE_STEPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x [5:0], pos_y [11:6], pixel_value [19:12], zero fill above
	input  logic [hca_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// cmd
	input  logic [hca_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// radius [3:0], peak_value [11:4], peak_x [17:12], peak_y [23:18], found [24]
	output logic [hca_pkg::M_DATA_W-1:0]     m_axis_tdata,
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hca_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hca_pkg::*;

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int RW = (MAX_RADII > 1) ? $clog2(MAX_RADII) : 1;
	localparam int AW = RW + YW + XW;
	localparam int DEPTH = 1 << AW;
	localparam int NUM_ANGLES = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;
	localparam logic [KW-1:0] K_LAST = KW'(NUM_ANGLES - 1);

	hca_state_t state_q, state_nx;

	// configuration registers
	logic [DIM_W-1:0]  image_width_q, image_height_q;
	logic [RCNT_W-1:0] radius_count_q;
	logic [VAL_W-1:0]  vote_weight_q, peak_threshold_q;
	logic [DIM_W-1:0]  eff_w, eff_h;
	logic [RCNT_W-1:0] eff_r;

	// sequencer counters and item registers
	logic [RCNT_W-1:0] r_q;
	logic [KW-1:0]     k_q;
	logic [DIM_W-1:0]  x_q, y_q;
	logic [POS_W-1:0]  px_q, py_q;
	logic signed [OFF_W-1:0] off_x_q;
	logic [AW-1:0]     vaddr_q, clr_addr_q;

	// shared multiplier and rounding
	logic signed [TRIG_W-1:0] trig;
	logic signed [PROD_W-1:0] prod;
	logic signed [RND_W-1:0]  rnd;
	logic signed [OFF_W-1:0]  off;
	logic signed [COORD_W-1:0] ca, cb;
	logic        vote_hit;
	logic [AW-1:0] vote_addr;

	// memory ports
	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q, wr_data;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             wr_en;
	logic [VAL_W:0]   sum;

	// scan pipeline and running maximum
	logic             scan_valid_s1;
	logic [DIM_W-1:0] sx_s1, sy_s1;
	logic [VAL_W-1:0] best_q;
	logic [DIM_W-1:0] bx_q, by_q;

	// control decodes
	logic in_acc, region_empty, vote_ok, vote_last, scan_last, layer_last, out_load;

	// output register
	logic             out_valid_q;
	logic [RAD_W-1:0] o_radius_q;
	logic [VAL_W-1:0] o_peak_q;
	logic [POS_W-1:0] o_x_q, o_y_q;
	logic             o_found_q, o_last_q;

	// effective sizes clamp to the built maxima
	assign eff_w = (32'(image_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width_q;
	assign eff_h = (32'(image_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height_q;
	assign eff_r = (32'(radius_count_q) > MAX_RADII) ? RCNT_W'(MAX_RADII) : radius_count_q;

	assign in_acc       = s_axis_tvalid && s_axis_tready;
	assign region_empty = (eff_w == '0) || (eff_h == '0);
	assign vote_ok      = (s_axis_tdata[PIX_W+2*POS_W-1:2*POS_W] != '0)
		&& ({1'b0, s_axis_tdata[POS_W-1:0]} < eff_w)
		&& ({1'b0, s_axis_tdata[2*POS_W-1:POS_W]} < eff_h)
		&& (eff_r != '0);
	assign vote_last    = (k_q == K_LAST) && (r_q == eff_r - 1'b1);
	assign scan_last    = (x_q == eff_w - 1'b1) && (y_q == eff_h - 1'b1);
	assign layer_last   = (r_q == eff_r - 1'b1);

	// shared multiplier: cosine in the COS state, sine in the SIN state that follows it
	always_comb begin
		trig = (state_q == ST_COS) ? cos_q14(k_q) : sin_q14(k_q);
		prod = $signed({1'b0, r_q}) * trig;
		rnd  = RND_W'(prod) + HALF_LSB;
		off  = rnd[RND_W-1:FRAC_W];
	end

	// centre coordinates and bound check
	always_comb begin
		ca = $signed(COORD_W'(px_q)) - COORD_W'(off_x_q);
		cb = $signed(COORD_W'(py_q)) - COORD_W'(off);
		vote_hit = !ca[COORD_W-1] && !cb[COORD_W-1]
			&& (ca[COORD_W-2:0] < (COORD_W-1)'(eff_w))
			&& (cb[COORD_W-2:0] < (COORD_W-1)'(eff_h));
		vote_addr = {RW'(r_q), YW'(cb[COORD_W-2:0]), XW'(ca[COORD_W-2:0])};
	end

	// saturating add of the vote weight
	assign sum = {1'b0, rd_data_q} + {1'b0, vote_weight_q};

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (s_axis_tuser == CMD_REPORT) begin
						if (eff_r == '0) state_nx = ST_CLEAR;
						else if (region_empty) state_nx = ST_EMIT;
						else state_nx = ST_SCAN;
					end else if (vote_ok) begin
						state_nx = ST_COS;
					end
				end
			end
			ST_COS: state_nx = ST_SIN;
			ST_SIN: begin
				if (vote_hit) state_nx = ST_UPD;
				else if (vote_last) state_nx = ST_IDLE;
				else state_nx = ST_COS;
			end
			ST_UPD: state_nx = vote_last ? ST_IDLE : ST_COS;
			ST_SCAN: begin
				if (scan_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (out_load) begin
					if (layer_last) state_nx = ST_CLEAR;
					else if (region_empty) state_nx = ST_EMIT;
					else state_nx = ST_SCAN;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = vaddr_q;
		wr_data       = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
		rd_addr       = {RW'(r_q), YW'(y_q), XW'(x_q)};
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			ST_IDLE: s_axis_tready = 1'b1;
			ST_SIN:  rd_addr = vote_addr;
			ST_UPD:  wr_en = 1'b1;
			ST_EMIT: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	// vote store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_addr_q       <= '0;
			scan_valid_s1    <= 1'b0;
			out_valid_q      <= 1'b0;
			image_width_q    <= RST_IMAGE_WIDTH;
			image_height_q   <= RST_IMAGE_HEIGHT;
			radius_count_q   <= RST_RADIUS_COUNT;
			vote_weight_q    <= RST_VOTE_WEIGHT;
			peak_threshold_q <= RST_PEAK_THRESHOLD;
		end else begin
			state_q       <= state_nx;
			clr_addr_q    <= (state_q == ST_CLEAR) ? clr_addr_q + 1'b1 : '0;
			scan_valid_s1 <= (state_q == ST_SCAN);
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:    image_width_q    <= cfg_data[DIM_W-1:0];
					REG_IMAGE_HEIGHT:   image_height_q   <= cfg_data[DIM_W-1:0];
					REG_RADIUS_COUNT:   radius_count_q   <= cfg_data[RCNT_W-1:0];
					REG_VOTE_WEIGHT:    vote_weight_q    <= cfg_data;
					REG_PEAK_THRESHOLD: peak_threshold_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// registers change only between requests
	assign cfg_ready = (state_q == ST_IDLE);

	// sequencer counters and datapath registers
	always_ff @(posedge clk) begin
		sx_s1 <= x_q;
		sy_s1 <= y_q;
		if (scan_valid_s1 && (rd_data_q > best_q)) begin
			best_q <= rd_data_q;
			bx_q   <= sx_s1;
			by_q   <= sy_s1;
		end
		unique case (state_q)
			ST_IDLE: begin
				px_q   <= s_axis_tdata[POS_W-1:0];
				py_q   <= s_axis_tdata[2*POS_W-1:POS_W];
				r_q    <= '0;
				k_q    <= '0;
				x_q    <= '0;
				y_q    <= '0;
				best_q <= '0;
				bx_q   <= '0;
				by_q   <= '0;
			end
			ST_COS: off_x_q <= off;
			ST_SIN: begin
				vaddr_q <= vote_addr;
				if (!vote_hit) begin
					if (k_q == K_LAST) begin
						k_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
			end
			ST_UPD: begin
				if (k_q == K_LAST) begin
					k_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_SCAN: begin
				if (x_q == eff_w - 1'b1) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					r_q    <= r_q + 1'b1;
					x_q    <= '0;
					y_q    <= '0;
					best_q <= '0;
					bx_q   <= '0;
					by_q   <= '0;
				end
			end
			default: ;
		endcase
		// report line into the output register
		if (out_load) begin
			o_radius_q <= r_q[RAD_W-1:0];
			o_peak_q   <= best_q;
			o_x_q      <= bx_q[POS_W-1:0];
			o_y_q      <= by_q[POS_W-1:0];
			o_found_q  <= (best_q >= peak_threshold_q);
			o_last_q   <= layer_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = M_DATA_W'({o_found_q, o_y_q, o_x_q, o_peak_q, o_radius_q});

`ifndef ASSERT_OFF
	// a memory update always follows a hit found in the sine step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> ($past(state_q) == ST_SIN && $past(vote_hit)))
		else $error("update without a preceding hit");

	// the final report line is followed by the clear sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && layer_last) |=> (state_q == ST_CLEAR))
		else $error("no clear after final report line");

	// the scan pipeline is empty whenever a new request can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !scan_valid_s1)
		else $error("scan still in flight while idle");

	// found flag agrees with the threshold of the loaded peak
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (o_found_q == (o_peak_q >= peak_threshold_q)))
		else $error("found flag mismatch");
`endif

endmodule
